FILE: hw/rtl/tkc_pkg.sv
`default_nettype none

package tkc_pkg;

    localparam int ENTRIES_DEF   = 64;
    localparam int KEY_WORDS_DEF = 4;

    localparam int OP_W      = 2;
    localparam int ID_W      = 32;
    localparam int WORD_W    = 64;
    localparam int MAX_WORDS = 4;
    localparam int MAX_KEY_W = MAX_WORDS * WORD_W;
    localparam int STATUS_W  = 3;
    localparam int USED_W    = 7;

    // request layout: op, table_id, new_key_w0..w3
    localparam int S_OP_LSB   = 0;
    localparam int S_ID_LSB   = S_OP_LSB + OP_W;
    localparam int S_KEY_LSB  = S_ID_LSB + ID_W;
    localparam int S_BITS     = S_KEY_LSB + MAX_KEY_W;
    localparam int S_TDATA_W  = ((S_BITS + 7) / 8) * 8;

    // result layout: status, out_key_w0..w3, entries_used
    localparam int M_STATUS_LSB = 0;
    localparam int M_KEY_LSB    = M_STATUS_LSB + STATUS_W;
    localparam int M_USED_LSB   = M_KEY_LSB + MAX_KEY_W;
    localparam int M_BITS       = M_USED_LSB + USED_W;
    localparam int M_TDATA_W    = ((M_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_LOOKUP     = 2'd0;
    localparam logic [OP_W-1:0] OP_INSERT     = 2'd1;
    localparam logic [OP_W-1:0] OP_INSERT_ROOM = 2'd2;
    localparam logic [OP_W-1:0] OP_EVICT      = 2'd3;

    localparam logic [STATUS_W-1:0] STS_OK       = 3'd0;
    localparam logic [STATUS_W-1:0] STS_MISS     = 3'd1;
    localparam logic [STATUS_W-1:0] STS_PRESENT  = 3'd2;
    localparam logic [STATUS_W-1:0] STS_EVICTED0 = 3'd3;
    localparam logic [STATUS_W-1:0] STS_FULL     = 3'd4;
    localparam logic [STATUS_W-1:0] STS_INVALID  = 3'd5;

endpackage

`default_nettype wire

FILE: hw/rtl/tkc_first_one.sv
`default_nettype none

module tkc_first_one #(
    parameter int ENTRIES = tkc_pkg::ENTRIES_DEF,
    parameter int IDX_W   = (ENTRIES > 1) ? $clog2(ENTRIES) : 1
) (
    input  wire logic [ENTRIES-1:0] vec,
    output logic                    found,
    output logic [IDX_W-1:0]        idx
);

    // lowest set bit wins
    always_comb
    begin
        found = 1'b0;
        idx   = '0;
        for (int i = ENTRIES - 1; i >= 0; i--)
        begin
            if (vec[i])
            begin
                found = 1'b1;
                idx   = IDX_W'(i);
            end
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/table_key_cache.sv
`default_nettype none

// table_key_cache: fully associative map from a 32-bit table id to a data key
// s_axis carries one request (op, table_id, new key words); m_axis returns one
// result per request (status, key now held for the id, occupied slot count).
// id tags sit in flops and are compared in parallel when a request is taken;
// keys sit in a synchronous memory (registered read), one full key per row.
// timing: the request is accepted in ST_IDLE with the tag compare registered;
// ST_SEL does the priority pick over the match and empty vectors, the tag/key
// writes and the key memory read; ST_RESP loads the result into the output
// register, raising m_tvalid. only one request is in flight at a time, so a
// new request is taken only after the result of the last one is loaded.
// s_tready is high only while no request is in flight; a finished result sits
// in the output register, and if m_tready is low when the next result is due
// the block holds that result in its response state until the slot frees.
// reset clears all valid bits, the used count and the handshake state; key
// memory contents are left as they are and are only used from valid slots.
module table_key_cache #(
    parameter int ENTRIES   = tkc_pkg::ENTRIES_DEF,
    parameter int KEY_WORDS = tkc_pkg::KEY_WORDS_DEF
) (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    // op, table_id, new_key_w0, new_key_w1, new_key_w2, new_key_w3
    input  wire logic [tkc_pkg::S_TDATA_W-1:0] s_tdata,
    input  wire logic                         s_tvalid,
    output logic                              s_tready,
    // status, out_key_w0, out_key_w1, out_key_w2, out_key_w3, entries_used
    output logic [tkc_pkg::M_TDATA_W-1:0]     m_tdata,
    output logic                              m_tvalid,
    input  wire logic                         m_tready
);

    import tkc_pkg::*;

    localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
    localparam int CNT_W = $clog2(ENTRIES + 1);
    localparam int KEY_W = KEY_WORDS * WORD_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_SEL  = 2'd1;
    localparam logic [1:0] ST_RESP = 2'd2;

    localparam logic [1:0] SRC_NONE = 2'd0;
    localparam logic [1:0] SRC_MEM  = 2'd1;
    localparam logic [1:0] SRC_NEW  = 2'd2;

    logic [1:0]          state_reg, state_next;
    logic [ID_W-1:0]     tag_reg [ENTRIES];
    logic [ENTRIES-1:0]  valid_reg;
    logic [CNT_W-1:0]    count_reg, count_next;
    logic [ENTRIES-1:0]  hit_vec_reg, hit_vec_next;
    logic [OP_W-1:0]     op_reg;
    logic [ID_W-1:0]     id_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [STATUS_W-1:0] status_reg, status_next;
    logic [1:0]          src_reg, src_next;

    logic [KEY_W-1:0]    key_mem [ENTRIES];
    logic [KEY_W-1:0]    rd_data_reg;

    logic                out_valid_reg;
    logic [M_TDATA_W-1:0] out_data_reg, out_data_next;

    logic                accept;
    logic [ID_W-1:0]     s_id;
    logic                hit_found, empty_found;
    logic [IDX_W-1:0]    hit_idx, empty_idx;
    logic                fill_en, clear_en;
    logic [IDX_W-1:0]    fill_idx;
    logic                load_out;
    logic [KEY_W-1:0]    key_sel;

    assign s_tready = (state_reg == ST_IDLE);
    assign accept   = s_tvalid && s_tready;
    assign s_id     = s_tdata[S_ID_LSB +: ID_W];
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // parallel tag compare on the incoming id
    always_comb
    begin
        for (int i = 0; i < ENTRIES; i++)
        begin
            hit_vec_next[i] = valid_reg[i] && (tag_reg[i] == s_id);
        end
    end

    tkc_first_one #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_hit_pick (
        .vec   (hit_vec_reg),
        .found (hit_found),
        .idx   (hit_idx)
    );

    tkc_first_one #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_empty_pick (
        .vec   (~valid_reg),
        .found (empty_found),
        .idx   (empty_idx)
    );

    // slot decision
    always_comb
    begin
        fill_en     = 1'b0;
        clear_en    = 1'b0;
        fill_idx    = empty_idx;
        count_next  = count_reg;
        status_next = status_reg;
        src_next    = src_reg;
        if (state_reg == ST_SEL)
        begin
            src_next = SRC_NONE;
            priority if (op_reg != OP_LOOKUP && id_reg == '0)
            begin
                status_next = STS_INVALID;
            end
            else if (op_reg == OP_LOOKUP)
            begin
                status_next = hit_found ? STS_OK : STS_MISS;
                src_next    = hit_found ? SRC_MEM : SRC_NONE;
            end
            else if (op_reg == OP_EVICT)
            begin
                if (hit_found)
                begin
                    clear_en    = 1'b1;
                    status_next = STS_OK;
                    if (count_reg != '0)
                    begin
                        count_next = CNT_W'(count_reg - CNT_W'(1));
                    end
                end
                else
                begin
                    status_next = STS_MISS;
                end
            end
            else if (hit_found)
            begin
                status_next = STS_PRESENT;
                src_next    = SRC_MEM;
            end
            else if (empty_found)
            begin
                fill_en     = 1'b1;
                status_next = STS_OK;
                src_next    = SRC_NEW;
                count_next  = CNT_W'(count_reg + CNT_W'(1));
            end
            else if (op_reg == OP_INSERT)
            begin
                fill_en     = 1'b1;
                fill_idx    = '0;
                status_next = STS_EVICTED0;
                src_next    = SRC_NEW;
            end
            else
            begin
                status_next = STS_FULL;
            end
        end
    end

    always_comb
    begin
        state_next = state_reg;
        load_out   = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    state_next = ST_SEL;
                end
            end
            ST_SEL:
            begin
                state_next = ST_RESP;
            end
            ST_RESP:
            begin
                if (!out_valid_reg || m_tready)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // result assembly
    always_comb
    begin
        unique case (src_reg)
            SRC_MEM:  key_sel = rd_data_reg;
            SRC_NEW:  key_sel = key_reg;
            default:  key_sel = '0;
        endcase
        out_data_next = '0;
        out_data_next[M_STATUS_LSB +: STATUS_W] = status_reg;
        out_data_next[M_KEY_LSB +: MAX_KEY_W]   = MAX_KEY_W'(key_sel);
        out_data_next[M_USED_LSB +: USED_W]     = USED_W'(count_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            valid_reg     <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            if (fill_en)
            begin
                valid_reg[fill_idx] <= 1'b1;
            end
            else if (clear_en)
            begin
                valid_reg[hit_idx] <= 1'b0;
            end
            if (load_out)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hit_vec_reg <= hit_vec_next;
            op_reg      <= s_tdata[S_OP_LSB +: OP_W];
            id_reg      <= s_id;
            key_reg     <= s_tdata[S_KEY_LSB +: KEY_W];
        end
        if (fill_en)
        begin
            tag_reg[fill_idx] <= id_reg;
        end
        else if (clear_en)
        begin
            tag_reg[hit_idx] <= '0;
        end
        status_reg <= status_next;
        src_reg    <= src_next;
        if (load_out)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // key memory: one full key per row, read data registered
    always_ff @(posedge clk)
    begin
        if (fill_en)
        begin
            key_mem[fill_idx] <= key_reg;
        end
        if (state_reg == ST_SEL)
        begin
            rd_data_reg <= key_mem[hit_idx];
        end
    end

endmodule

`default_nettype wire
